FILE: rtl/ddarc_pkg.sv
// ----------------------------------------------------------------------------
// ddarc_pkg
// Shared types and constants for the DDA ray wall column unit.
// ----------------------------------------------------------------------------
package ddarc_pkg;

   localparam int MapWidthDefault  = 64;
   localparam int MapHeightDefault = 64;
   localparam int MaxStepsDefault  = 128;

   localparam logic [10:0] ScreenHeightReset = 11'd480;
   localparam logic [23:0] DistMax = 24'hFFFFFF;
   localparam logic [15:0] LineMax = 16'hFFFF;

   localparam logic OpWrite = 1'b0;
   localparam logic OpCast  = 1'b1;

   localparam logic [0:0] RegScreenHeight = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_CHECK,
      ST_NUM,
      ST_DIV1,
      ST_LHSETUP,
      ST_DIV2,
      ST_FINISH,
      ST_OUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic clear_wr;   // write zero at clear address
      logic clear_inc;  // advance clear address
      logic load;       // capture a cast item
      logic cell_wr;    // write one map cell from the input item
      logic step;       // one DDA step
      logic num_setup;  // prepare first division
      logic div_step;   // one bit of the running division
      logic perp_load;  // capture the perpendicular distance
      logic lh_setup;   // prepare second division
      logic finish;     // form the result
      logic set_nohit;  // form a no-hit result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic start_out;  // start cell outside the map
      logic out_map;    // current cell outside the map
      logic wall;       // current cell is wall
      logic steps_done; // step bound reached
      logic div_done;
   } status_type;

endpackage

FILE: rtl/dda_ray_wall_column_unit.sv
// ----------------------------------------------------------------------------
// dda_ray_wall_column_unit
// Grid raycaster: stores a wall map and casts one ray per cast item.
// ----------------------------------------------------------------------------
// Usage: items arrive on the req_ channel. A write item (op 0) stores one map
// bit and gives no result, and writes may follow back to back. A cast item
// (op 1) walks the map cell by cell and gives one result on the rsp_ channel;
// one item is processed at a time.
// A cast tests whether the start cell lies inside the map, then takes DDA steps
// (one map read each), runs two bit-serial divisions and forms the result; a
// ray that starts outside the map, leaves it or runs out of steps gives a
// no-hit result. The map memory has a single port and the divider is shared
// by both divisions.
// After reset the map is swept clear, one cell per cycle (MapWidth and
// MapHeight each rounded up to a power of two, 4096 cells by default), and no
// item is taken until the sweep ends; APB writes are taken throughout.
// The result is held stable in its register while rsp_ready is low, and no
// new item is accepted until it has been transferred.
// screen_height is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module dda_ray_wall_column_unit #(
   parameter int MapWidth  = ddarc_pkg::MapWidthDefault,
   parameter int MapHeight = ddarc_pkg::MapHeightDefault,
   parameter int MaxSteps  = ddarc_pkg::MaxStepsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_op,
   input  logic [5:0]   req_cell_x,
   input  logic [5:0]   req_cell_y,
   input  logic         req_wall,
   input  logic [13:0]  req_pos_x,
   input  logic [13:0]  req_pos_y,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic [23:0]  req_side_dist_x,
   input  logic [23:0]  req_side_dist_y,
   input  logic [23:0]  req_delta_x,
   input  logic [23:0]  req_delta_y,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_no_hit,
   output logic         rsp_side,
   output logic [5:0]   rsp_hit_x,
   output logic [5:0]   rsp_hit_y,
   output logic [23:0]  rsp_perp_dist,
   output logic [15:0]  rsp_line_height,
   output logic [10:0]  rsp_slice_top,
   output logic [10:0]  rsp_slice_bottom,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [0:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import ddarc_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [10:0] height_ff;

   // Configuration register, written at the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= ScreenHeightReset;
      end else if (psel && penable && pwrite && paddr == RegScreenHeight) begin
         height_ff <= pwdata[10:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == RegScreenHeight) ? {21'b0, height_ff} : 32'b0;

   ddarc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   ddarc_datapath #(
      .MapWidth  (MapWidth),
      .MapHeight (MapHeight),
      .MaxSteps  (MaxSteps)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cell_x      (req_cell_x),
      .req_cell_y      (req_cell_y),
      .req_wall        (req_wall),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_dir_x       (req_dir_x),
      .req_dir_y       (req_dir_y),
      .req_side_dist_x (req_side_dist_x),
      .req_side_dist_y (req_side_dist_y),
      .req_delta_x     (req_delta_x),
      .req_delta_y     (req_delta_y),
      .screen_height   (height_ff),
      .no_hit          (rsp_no_hit),
      .side            (rsp_side),
      .hit_x           (rsp_hit_x),
      .hit_y           (rsp_hit_y),
      .perp_dist       (rsp_perp_dist),
      .line_height     (rsp_line_height),
      .slice_top       (rsp_slice_top),
      .slice_bottom    (rsp_slice_bottom)
   );

endmodule

FILE: rtl/ddarc_ram.sv
// ----------------------------------------------------------------------------
// ddarc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ddarc_ram #(
   parameter int Width = 1,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and registered read at one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ddarc_datapath.sv
// ----------------------------------------------------------------------------
// ddarc_datapath
// Map memory, DDA accumulators, a shared restoring divider and result forming.
// ----------------------------------------------------------------------------
module ddarc_datapath #(
   parameter int MapWidth  = ddarc_pkg::MapWidthDefault,
   parameter int MapHeight = ddarc_pkg::MapHeightDefault,
   parameter int MaxSteps  = ddarc_pkg::MaxStepsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ddarc_pkg::cmd_type   cmd,
   output ddarc_pkg::status_type status,
   input  logic [5:0]           req_cell_x,
   input  logic [5:0]           req_cell_y,
   input  logic                 req_wall,
   input  logic [13:0]          req_pos_x,
   input  logic [13:0]          req_pos_y,
   input  logic signed [15:0]   req_dir_x,
   input  logic signed [15:0]   req_dir_y,
   input  logic [23:0]          req_side_dist_x,
   input  logic [23:0]          req_side_dist_y,
   input  logic [23:0]          req_delta_x,
   input  logic [23:0]          req_delta_y,
   input  logic [10:0]          screen_height,
   output logic                 no_hit,
   output logic                 side,
   output logic [5:0]           hit_x,
   output logic [5:0]           hit_y,
   output logic [23:0]          perp_dist,
   output logic [15:0]          line_height,
   output logic [10:0]          slice_top,
   output logic [10:0]          slice_bottom
);
   import ddarc_pkg::*;

   localparam int XW    = $clog2(MapWidth);
   localparam int YW    = $clog2(MapHeight);
   localparam int AW    = XW + YW;
   localparam int Depth = 1 << AW;
   localparam int CW    = 10;             // signed cell coordinate
   localparam int SW    = $clog2(MaxSteps + 1);
   localparam int AccW  = 34;             // 24 + 10 bits of growth, never wraps
   localparam int DW    = 6;              // divider counter

   // Memory address selection.
   logic [AW-1:0] addr;
   logic [AW:0]   clr_ff, clr_in;
   logic          wr_en, wr_data, rd_data;
   logic [8:0]    cx_w, cy_w;

   logic signed [CW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic [AccW-1:0] dx_ff, dy_ff, ddx_ff, ddy_ff;
   logic            sxn_ff, syn_ff, side_ff;
   logic [13:0]     px_ff, py_ff;
   logic signed [15:0] dirx_ff, diry_ff;
   logic [SW-1:0]   n_ff;

   // Divider: quotient of num over den, 41 bit dividend max.
   logic [40:0] dvd_ff;
   logic [23:0] den_ff;
   logic [24:0] rem_ff;
   logic [40:0] quo_ff;
   logic [DW-1:0] cnt_ff;
   logic [DW-1:0] cnt_max_ff;
   logic          sat_ff;  // divisor zero or result fixed
   logic [23:0]   fixed_ff;
   logic [23:0]   perp_ff;

   logic          nohit_ff;
   logic [15:0]   lh_ff;
   logic [10:0]   ds_ff, de_ff;

   logic signed [CW+8:0] num;
   logic signed [15:0]   dsel;
   logic [15:0]          adir;
   logic [18:0]          anum;
   logic [24:0]          rem_sh, rem_sub;
   logic [23:0]          q24;
   logic [16:0]          lh_sum;
   logic [15:0]          lh_v;
   logic [10:0]          half;
   logic [15:0]          lh_half;

   always_comb begin
      cx_w = {3'b0, req_cell_x};
      cy_w = {3'b0, req_cell_y};
      if (cmd.clear_wr) begin
         addr = clr_ff[AW-1:0];
      end else if (cmd.cell_wr) begin
         addr = {cy_w[YW-1:0], cx_w[XW-1:0]};
      end else begin
         addr = {my_in[YW-1:0], mx_in[XW-1:0]};
      end
      wr_en   = cmd.clear_wr ||
                (cmd.cell_wr && (cx_w < 9'(MapWidth)) && (cy_w < 9'(MapHeight)));
      wr_data = cmd.clear_wr ? 1'b0 : req_wall;
   end

   ddarc_ram #(.Width(1), .Depth(Depth)) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Clear sweep counter.
   always_comb begin
      clr_in = cmd.clear_inc ? clr_ff + 1'b1 : clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Next cell of the walk; the step in progress reads its map bit.
   always_comb begin
      mx_in = mx_ff;
      my_in = my_ff;
      if (cmd.step) begin
         if (dx_ff < dy_ff) begin
            mx_in = sxn_ff ? mx_ff - 1'b1 : mx_ff + 1'b1;
         end else begin
            my_in = syn_ff ? my_ff - 1'b1 : my_ff + 1'b1;
         end
      end
   end

   // DDA walk registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mx_ff   <= CW'(req_pos_x[13:8]);
         my_ff   <= CW'(req_pos_y[13:8]);
         dx_ff   <= AccW'(req_side_dist_x);
         dy_ff   <= AccW'(req_side_dist_y);
         ddx_ff  <= AccW'(req_delta_x);
         ddy_ff  <= AccW'(req_delta_y);
         sxn_ff  <= req_dir_x[15];
         syn_ff  <= req_dir_y[15];
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         dirx_ff <= req_dir_x;
         diry_ff <= req_dir_y;
         n_ff    <= '0;
         side_ff <= 1'b0;
      end else if (cmd.step) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         n_ff  <= n_ff + 1'b1;
         if (dx_ff < dy_ff) begin
            dx_ff   <= dx_ff + ddx_ff;
            side_ff <= 1'b0;
         end else begin
            dy_ff   <= dy_ff + ddy_ff;
            side_ff <= 1'b1;
         end
      end
   end

   // Numerator of the perpendicular distance, Q8.8 signed.
   always_comb begin
      if (side_ff) begin
         num = (CW+9)'($signed({my_ff, 8'b0})) - (CW+9)'($signed({1'b0, py_ff})) +
               (syn_ff ? (CW+9)'(256) : (CW+9)'(0));
         dsel = diry_ff;
      end else begin
         num = (CW+9)'($signed({mx_ff, 8'b0})) - (CW+9)'($signed({1'b0, px_ff})) +
               (sxn_ff ? (CW+9)'(256) : (CW+9)'(0));
         dsel = dirx_ff;
      end
      adir = dsel[15] ? 16'(-dsel) : dsel;
      anum = num[CW+8] ? 19'(-num) : 19'(num);
   end

   // One restoring division step.
   always_comb begin
      rem_sh  = {rem_ff[23:0], dvd_ff[40]};
      rem_sub = rem_sh - {1'b0, den_ff};
      q24     = (|quo_ff[40:24]) ? DistMax : quo_ff[23:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.num_setup) begin
         dvd_ff     <= {4'b0, anum, 18'b0};
         den_ff     <= 24'(adir);
         rem_ff     <= '0;
         quo_ff     <= '0;
         cnt_ff     <= '0;
         cnt_max_ff <= DW'(41);
         sat_ff     <= (dsel == 16'sd0) || (num == '0) ||
                       (num[CW+8] != dsel[15]);
         fixed_ff   <= (dsel == 16'sd0) ? DistMax : 24'd0;
      end else if (cmd.lh_setup) begin
         dvd_ff     <= {18'b0, screen_height, 12'b0};
         den_ff     <= perp_ff;
         rem_ff     <= '0;
         quo_ff     <= '0;
         cnt_ff     <= '0;
         cnt_max_ff <= DW'(41);
         sat_ff     <= (screen_height == 11'd0) || (perp_ff == 24'd0);
         fixed_ff   <= (screen_height == 11'd0) ? 24'd0 : 24'(LineMax);
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[39:0], 1'b0};
         cnt_ff <= cnt_ff + 1'b1;
         if (!rem_sub[24]) begin
            rem_ff <= rem_sub;
            quo_ff <= {quo_ff[39:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[39:0], 1'b0};
         end
      end
   end

   // Perpendicular distance capture at the end of the first division.
   always_ff @(posedge clock) begin
      if (cmd.perp_load) begin
         perp_ff <= sat_ff ? fixed_ff : q24;
      end
   end

   // Line height and draw range.
   always_comb begin
      lh_sum  = (|quo_ff[40:16]) ? 17'(LineMax) : {1'b0, quo_ff[15:0]};
      lh_v    = sat_ff ? fixed_ff[15:0] : lh_sum[15:0];
      half    = {1'b0, screen_height[10:1]};
      lh_half = {1'b0, lh_v[15:1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.set_nohit) begin
         nohit_ff <= 1'b1;
         lh_ff    <= '0;
         ds_ff    <= '0;
         de_ff    <= '0;
      end else if (cmd.finish) begin
         nohit_ff <= 1'b0;
         lh_ff    <= lh_v;
         ds_ff    <= (lh_half > 16'(half)) ? 11'd0 : half - lh_half[10:0];
         if (17'(lh_half) + 17'(half) >= 17'(screen_height)) begin
            de_ff <= (screen_height == 11'd0) ? 11'd0 : screen_height - 1'b1;
         end else begin
            de_ff <= 11'(lh_half + 16'(half));
         end
      end
   end

   // Status back to the controller.
   always_comb begin
      status.clear_done = clr_ff[AW];
      status.start_out  = ({3'b0, px_ff[13:8]} >= 9'(MapWidth)) ||
                          ({3'b0, py_ff[13:8]} >= 9'(MapHeight));
      status.out_map    = mx_ff[CW-1] || my_ff[CW-1] ||
                          (mx_ff >= CW'(MapWidth)) || (my_ff >= CW'(MapHeight));
      status.wall       = rd_data;
      status.steps_done = (n_ff == SW'(MaxSteps));
      status.div_done   = (cnt_ff == cnt_max_ff);
   end

   assign no_hit       = nohit_ff;
   assign side         = nohit_ff ? 1'b0 : side_ff;
   assign hit_x        = nohit_ff ? 6'd0 : 6'(mx_ff);
   assign hit_y        = nohit_ff ? 6'd0 : 6'(my_ff);
   assign perp_dist    = nohit_ff ? 24'd0 : perp_ff;
   assign line_height  = lh_ff;
   assign slice_top    = ds_ff;
   assign slice_bottom = de_ff;

endmodule

FILE: rtl/ddarc_control.sv
// ----------------------------------------------------------------------------
// ddarc_control
// Sequencer for map clearing, cell writes, the DDA walk and both divisions.
// ----------------------------------------------------------------------------
module ddarc_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_op,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ddarc_pkg::cmd_type    cmd,
   input  ddarc_pkg::status_type status
);
   import ddarc_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_wr  = 1'b1;
               cmd.clear_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OpWrite) begin
                  cmd.cell_wr = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (status.start_out) begin
               cmd.set_nohit = 1'b1;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.steps_done) begin
               cmd.set_nohit = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.out_map) begin
               cmd.set_nohit = 1'b1;
               state_in      = ST_OUT;
            end else if (status.wall) begin
               cmd.num_setup = 1'b1;
               state_in      = ST_DIV1;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DIV1: begin
            if (status.div_done) begin
               state_in = ST_NUM;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_NUM: begin
            cmd.perp_load = 1'b1;
            state_in      = ST_LHSETUP;
         end
         ST_LHSETUP: begin
            cmd.lh_setup = 1'b1;
            state_in     = ST_DIV2;
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DDA ray wall column unit: map writes and ray
// casts are sent over the req_ channel, each cast's wall slice is predicted
// from a private copy of the map and the screen height, and every rsp_
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import ddarc_pkg::*;

   localparam int MapW = 64;
   localparam int MapH = 64;
   localparam int StepLimit = 128;
   localparam int WatchdogLimit = 200000;

   typedef struct packed {
      logic        op;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        wall;
      logic [13:0] pos_x;
      logic [13:0] pos_y;
      logic [15:0] dir_x;
      logic [15:0] dir_y;
      logic [23:0] sd_x;
      logic [23:0] sd_y;
      logic [23:0] dl_x;
      logic [23:0] dl_y;
   } ray_item_type;

   typedef struct packed {
      logic        no_hit;
      logic        side;
      logic [5:0]  hit_x;
      logic [5:0]  hit_y;
      logic [23:0] perp_dist;
      logic [15:0] line_height;
      logic [10:0] slice_top;
      logic [10:0] slice_bottom;
   } slice_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ray_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   slice_type rsp_slice;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [0:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // Predictor state.
   bit model_map [MapW*MapH];
   int unsigned model_height = 32'(ScreenHeightReset);
   slice_type expected_slices [$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int casts_sent = 0;
   int writes_sent = 0;
   int slices_checked = 0;
   int quiet_cycles = 0;

   dda_ray_wall_column_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_item.op), .req_cell_x(req_item.cell_x), .req_cell_y(req_item.cell_y),
      .req_wall(req_item.wall), .req_pos_x(req_item.pos_x), .req_pos_y(req_item.pos_y),
      .req_dir_x(req_item.dir_x), .req_dir_y(req_item.dir_y),
      .req_side_dist_x(req_item.sd_x), .req_side_dist_y(req_item.sd_y),
      .req_delta_x(req_item.dl_x), .req_delta_y(req_item.dl_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_no_hit(rsp_slice.no_hit), .rsp_side(rsp_slice.side),
      .rsp_hit_x(rsp_slice.hit_x), .rsp_hit_y(rsp_slice.hit_y),
      .rsp_perp_dist(rsp_slice.perp_dist), .rsp_line_height(rsp_slice.line_height),
      .rsp_slice_top(rsp_slice.slice_top), .rsp_slice_bottom(rsp_slice.slice_bottom),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Perpendicular distance from a Q8.8 numerator and a Q2.14 direction.
   function automatic logic [23:0] wall_distance(longint num, longint dir);
      longint unsigned q;
      if (dir == 0) return DistMax;
      if (num == 0 || ((num < 0) != (dir < 0))) return 24'd0;
      q = 64'(((num < 0 ? -num : num) << 18) / (dir < 0 ? -dir : dir));
      return (q > 64'hFFFFFF) ? DistMax : q[23:0];
   endfunction

   // Walk the grid for one cast and form the expected wall slice.
   function automatic slice_type cast_slice(ray_item_type it);
      slice_type s;
      longint dirx, diry, mx, my, stx, sty, num;
      longint unsigned dx, dy, perp, lh, h, half, de;
      bit hit;
      bit sd;
      s = '0;
      hit = 0;
      sd = 0;
      dirx = longint'(signed'(it.dir_x));
      diry = longint'(signed'(it.dir_y));
      dx = 64'(it.sd_x);
      dy = 64'(it.sd_y);
      mx = longint'(it.pos_x >> 8);
      my = longint'(it.pos_y >> 8);
      stx = dirx < 0 ? -1 : 1;
      sty = diry < 0 ? -1 : 1;
      if (mx < MapW && my < MapH) begin
         for (int n = 0; n < StepLimit; n++) begin
            if (dx < dy) begin
               dx += 64'(it.dl_x); mx += stx; sd = 0;
            end else begin
               dy += 64'(it.dl_y); my += sty; sd = 1;
            end
            if (mx < 0 || my < 0 || mx >= MapW || my >= MapH) break;
            if (model_map[my*MapW + mx]) begin
               hit = 1;
               break;
            end
         end
      end
      if (!hit) begin
         s.no_hit = 1'b1;
         return s;
      end
      if (!sd) begin
         num = mx*256 - longint'(it.pos_x) + (stx < 0 ? 256 : 0);
         perp = 64'(wall_distance(num, dirx));
      end else begin
         num = my*256 - longint'(it.pos_y) + (sty < 0 ? 256 : 0);
         perp = 64'(wall_distance(num, diry));
      end
      h = 64'(model_height);
      if (h == 0) lh = 0;
      else if (perp == 0) lh = 64'(LineMax);
      else begin
         lh = (h << 12) / perp;
         if (lh > 64'(LineMax)) lh = 64'(LineMax);
      end
      half = h / 2;
      de = lh/2 + half;
      if (de >= h) de = (h == 0) ? 0 : h - 1;
      s.side = sd;
      s.hit_x = mx[5:0];
      s.hit_y = my[5:0];
      s.perp_dist = perp[23:0];
      s.line_height = lh[15:0];
      s.slice_top = (lh/2 > half) ? 11'd0 : 11'(half - lh/2);
      s.slice_bottom = de[10:0];
      return s;
   endfunction

   // Send one item; the prediction is taken at the moment of transfer.
   task automatic send_item(ray_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (it.op == OpWrite) begin
         model_map[it.cell_y*MapW + it.cell_x] = it.wall;
         writes_sent++;
      end else begin
         expected_slices.push_back(cast_slice(it));
         casts_sent++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_slices.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   // Write screen_height while the unit is idle, then read it back.
   task automatic set_height(int unsigned h);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= RegScreenHeight; pwdata <= h;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0; pwrite <= 1'b0;
      model_height = h & 32'h7FF;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[10:0] != model_height[10:0]) begin
         $display("%0t: screen_height read: expected %0d, actual %0d",
                  $time, model_height, prdata[10:0]);
         mismatches++;
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   function automatic ray_item_type map_write(int x, int y, bit w);
      ray_item_type it;
      it = '0;
      it.op = OpWrite; it.cell_x = 6'(x); it.cell_y = 6'(y); it.wall = w;
      return it;
   endfunction

   function automatic ray_item_type random_cast();
      ray_item_type it;
      it = '0;
      it.op = OpCast;
      it.cell_x = 6'($urandom); it.cell_y = 6'($urandom); it.wall = 1'($urandom);
      // Start positions span the 14-bit range, all inside the 64 by 64 map.
      it.pos_x = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(16383));
      it.pos_y = 14'($urandom);
      it.dir_x = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom);
      it.dir_y = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom);
      case ($urandom_range(3))
         0: begin
            it.sd_x = 24'($urandom); it.sd_y = 24'($urandom);
            it.dl_x = 24'($urandom); it.dl_y = 24'($urandom);
         end
         default: begin
            it.sd_x = 24'($urandom_range(8192)); it.sd_y = 24'($urandom_range(8192));
            it.dl_x = 24'($urandom_range(1, 20000)); it.dl_y = 24'($urandom_range(1, 20000));
         end
      endcase
      return it;
   endfunction

   task automatic test_directed();
      ray_item_type it;
      // Build walls on three sides of a square round the middle, plus edge
      // cells and an overwrite of one of them back to open.
      for (int k = 20; k <= 40; k += 5) begin
         send_item(map_write(k, 20, 1));
         send_item(map_write(k, 40, 1));
         send_item(map_write(20, k, 1));
      end
      send_item(map_write(63, 63, 1));
      send_item(map_write(0, 0, 1));
      send_item(map_write(0, 0, 0));
      it = '0; it.op = OpCast;
      // Start cell itself is a wall: never tested, ray walks on.
      it.pos_x = 14'd20 << 8; it.pos_y = 14'd30 << 8;
      it.dir_x = 16'sh4000; it.dir_y = 16'sh0000;
      it.sd_x = 24'd4096; it.sd_y = 24'hFFFFFF; it.dl_x = 24'd4096; it.dl_y = 24'hFFFFFF;
      send_item(it);
      // Hit on x side going negative.
      it.pos_x = 14'h1A80; it.dir_x = 16'sh8000;
      send_item(it);
      // Zero x direction: the ray steps towards +x and leaves the map.
      it.dir_x = 16'sh0000;
      send_item(it);
      // Two rays leaving the map, one starting in the far corner cell.
      it.pos_x = 14'h3FFF; it.pos_y = 14'h3FFF;
      send_item(it);
      it.pos_x = 14'd2 << 8; it.pos_y = 14'd2 << 8; it.dir_x = 16'sh7FFF;
      it.sd_x = 24'd0; it.dl_x = 24'd0;
      send_item(it);
      // Direction of one unit on the hit axis: the distance saturates.
      it.pos_x = 14'h1E80; it.pos_y = 14'h1E00; it.dir_x = 16'sh0001;
      it.dir_y = 16'shFFFF; it.sd_x = 24'hFFFFFF; it.sd_y = 24'd0;
      it.dl_y = 24'd100;
      send_item(it);
      wait_drained();
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(3) == 0) begin
            ray_item_type w;
            w = map_write(int'($urandom_range(63)), int'($urandom_range(63)),
                          $urandom_range(9) < 3);
            send_item(w);
         end else begin
            send_item(random_cast());
         end
      end
      wait_drained();
   endtask

   // Receiver: stall at random, check each transferred slice.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_slices.size() == 0) begin
            $display("%0t: slice with nothing expected: actual %p", $time, rsp_slice);
            mismatches++;
         end else begin
            slice_type e;
            e = expected_slices.pop_front();
            if (e !== rsp_slice) begin
               $display("%0t: slice mismatch: expected %p, actual %p", $time, e, rsp_slice);
               mismatches++;
            end
            slices_checked++;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchdogLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      set_height(11'd1);
      test_random(350, 0, 0);
      set_height(11'd2047);
      test_random(350, 72, 0);
      set_height(11'd0);
      test_random(50, 0, 72);
      set_height(11'($urandom_range(1, 2047)));
      test_random(300, 0, 72);
      set_height(11'd480);
      test_random(350, 19, 19);
      $display("Covered %0d casts and %0d map writes; %0d slices checked.",
               casts_sent, writes_sent, slices_checked);
      if (mismatches == 0 && expected_slices.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
